### sv/qtl_pkg.sv
// Q-table learner package: operation codes, sequencer states, update unit
// transaction types, field widths and configuration defaults.
// No dependencies.
package qtl_pkg;

  localparam int STATE_IN_W = 6;
  localparam int ACT_IN_W   = 2;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 2'd2;

  localparam logic [FRAC_W-1:0] EXPLORE_RST  = 16'd6554;
  localparam logic [FRAC_W-1:0] LEARN_RST    = 16'd6554;
  localparam logic [FRAC_W-1:0] DISCOUNT_RST = 16'd58982;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_LOAD   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPD_GO,
    ST_UPD_WAIT,
    ST_RD,
    ST_RD_DATA,
    ST_LOAD,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] q;
    logic signed [VAL_W-1:0] row_max;
    logic signed [VAL_W-1:0] reward;
    logic [FRAC_W-1:0]       gamma;
    logic [FRAC_W-1:0]       alpha;
  } upd_req_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
  } upd_rsp_t;

endpackage

### sv/qtl_mem.sv
// Q-table storage: single-port-write, single-port-read synchronous RAM,
// registered read data. No dependencies.
module qtl_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/qtl_update.sv
// Q-learning update datapath: four-stage pipeline computing
// sat(q + rnd(alpha * (r + rnd(gamma * max) - q))). Uses qtl_pkg.
module qtl_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qtl_pkg::upd_req_t req_i,
  output qtl_pkg::upd_rsp_t rsp_o
);

  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [48:0] prod1_d, prod1_q;
  logic signed [31:0] q1_q, r1_q, q2_q, q3_q;
  logic [15:0]        alpha1_q, alpha2_q;

  logic signed [48:0] gm_sum;
  logic signed [32:0] gm;
  logic signed [33:0] td_d, td_q;

  logic signed [50:0] prod2_d, prod2_q;
  logic signed [50:0] dl_sum;
  logic signed [34:0] delta;
  logic signed [35:0] newv;
  logic signed [31:0] value_d, value_q;

  assign prod1_d = 49'($signed({1'b0, req_i.gamma})) * 49'(req_i.row_max);

  assign gm_sum = prod1_q + 49'sd32768;
  assign gm     = gm_sum[48:16];
  assign td_d   = 34'(r1_q) + 34'(gm) - 34'(q1_q);

  assign prod2_d = 51'($signed({1'b0, alpha2_q})) * 51'(td_q);

  assign dl_sum = prod2_q + 51'sd32768;
  assign delta  = dl_sum[50:16];
  assign newv   = 36'(q3_q) + 36'(delta);

  always_comb begin
    if (newv[35:31] == 5'b00000 || newv[35:31] == 5'b11111) begin
      value_d = newv[31:0];
    end else if (newv[35]) begin
      value_d = 32'sh8000_0000;
    end else begin
      value_d = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q  <= prod1_d;
    q1_q     <= req_i.q;
    r1_q     <= req_i.reward;
    alpha1_q <= req_i.alpha;
    td_q     <= td_d;
    q2_q     <= q1_q;
    alpha2_q <= alpha1_q;
    prod2_q  <= prod2_d;
    q3_q     <= q2_q;
    value_q  <= value_d;
  end

  assign rsp_o.valid = v4_q;
  assign rsp_o.value = value_q;

endmodule

### sv/q_table_learner.sv
// Q-table learner top: sequencer, config registers, output register; uses
// qtl_pkg, qtl_mem and qtl_update. One transaction in flight: in_stall_o
// stays high until the result is handed to the output register. Row scan
// reads one entry per cycle from the table RAM. After reset a clearing pass
// zeroes the table with in_stall_o high.
module q_table_learner #(
  parameter int NUM_STATES  = 64,
  parameter int NUM_ACTIONS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qtl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qtl_pkg::FRAC_W-1:0]      cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [qtl_pkg::STATE_IN_W-1:0]  state_index_i,
  input  logic [qtl_pkg::ACT_IN_W-1:0]    act_index_i,
  input  logic [qtl_pkg::STATE_IN_W-1:0]  next_state_index_i,
  input  logic signed [qtl_pkg::VAL_W-1:0] reward_i,
  input  logic signed [qtl_pkg::VAL_W-1:0] write_value_i,
  input  logic [qtl_pkg::FRAC_W-1:0]      random_fraction_i,
  input  logic [qtl_pkg::ACT_IN_W-1:0]    random_action_i,
  input  logic [2:0]                      coin_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      chosen_action_o,
  output logic                            explored_o,
  output logic signed [qtl_pkg::VAL_W-1:0] read_value_o
);

  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(NUM_STATES);
  localparam int AIW    = $clog2(NUM_ACTIONS);
  localparam int CW     = $clog2(NUM_ACTIONS + 1);
  localparam int ST_IN  = 1 << qtl_pkg::STATE_IN_W;
  localparam int ACT_IN = 1 << qtl_pkg::ACT_IN_W;
  localparam int VW     = qtl_pkg::VAL_W;

  // index wrap tables
  logic [SW-1:0]  st_mod_tab  [ST_IN];
  logic [AIW-1:0] act_mod_tab [ACT_IN];

  for (genvar k = 0; k < ST_IN; k++) begin : g_st_mod
    assign st_mod_tab[k] = SW'(k % NUM_STATES);
  end
  for (genvar k = 0; k < ACT_IN; k++) begin : g_act_mod
    assign act_mod_tab[k] = AIW'(k % NUM_ACTIONS);
  end

  qtl_pkg::state_e state_q, state_d;
  qtl_pkg::op_e    op_q, op_d;

  logic [qtl_pkg::FRAC_W-1:0] explore_q, learn_q, discount_q;
  logic [AW-1:0]        clr_q, clr_d;
  logic [AW-1:0]        row_base_q, row_base_d, cur_addr_q, cur_addr_d;
  logic signed [VW-1:0] reward_q, reward_d, wval_q, wval_d;
  logic [2:0]           coins_q, coins_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic signed [VW-1:0] best_q, best_d;
  logic [AIW-1:0]       best_idx_q, best_idx_d;
  logic [1:0]           res_chosen_q, res_chosen_d;
  logic                 res_expl_q, res_expl_d;
  logic signed [VW-1:0] res_value_q, res_value_d;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_chosen_q, out_chosen_d;
  logic                 out_expl_q, out_expl_d;
  logic signed [VW-1:0] out_value_q, out_value_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [VW-1:0] mem_wd, mem_rd;

  qtl_pkg::upd_req_t upd_req;
  qtl_pkg::upd_rsp_t upd_rsp;

  logic          in_fire, out_free, exploit, take, coin_en;
  logic [CW-1:0] step;
  logic [3:0]    coins4;
  logic [AIW+1:0] rand_wide;
  logic [AW-1:0] in_addr, in_s_base, in_sp_base;

  assign in_stall_o = (state_q != qtl_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign exploit    = (17'(random_fraction_i) + 17'(explore_q)) < 17'h10000;

  assign in_s_base  = AW'(st_mod_tab[state_index_i] * NUM_ACTIONS);
  assign in_sp_base = AW'(st_mod_tab[next_state_index_i] * NUM_ACTIONS);
  assign in_addr    = in_s_base + AW'(act_mod_tab[act_index_i]);

  assign step    = idx_q - CW'(2);
  assign coins4  = {1'b0, coins_q};
  assign coin_en = (op_q == qtl_pkg::OP_SELECT) && (idx_q >= CW'(2)) &&
                   (step < CW'(3)) && coins4[step[1:0]];
  assign take    = ($signed(mem_rd) > best_q) ||
                   (($signed(mem_rd) == best_q) && coin_en);

  assign rand_wide = (AIW + 2)'(act_mod_tab[random_action_i]);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    clr_d        = clr_q;
    row_base_d   = row_base_q;
    cur_addr_d   = cur_addr_q;
    reward_d     = reward_q;
    wval_d       = wval_q;
    coins_d      = coins_q;
    idx_d        = idx_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    res_chosen_d = res_chosen_q;
    res_expl_d   = res_expl_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_chosen_d = out_chosen_q;
    out_expl_d   = out_expl_q;
    out_value_d  = out_value_q;
    mem_we       = 1'b0;
    mem_wa       = cur_addr_q;
    mem_wd       = wval_q;
    mem_re       = 1'b0;
    mem_ra       = row_base_q + AW'(idx_q);
    upd_req.valid   = 1'b0;
    upd_req.q       = $signed(mem_rd);
    upd_req.row_max = best_q;
    upd_req.reward  = reward_q;
    upd_req.gamma   = discount_q;
    upd_req.alpha   = learn_q;

    case (state_q)
      qtl_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = qtl_pkg::ST_IDLE;
        end
      end
      qtl_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d         = qtl_pkg::op_e'(action_i);
          cur_addr_d   = in_addr;
          row_base_d   = (action_i == qtl_pkg::OP_UPDATE) ? in_sp_base : in_s_base;
          reward_d     = reward_i;
          wval_d       = write_value_i;
          coins_d      = coin_bits_i;
          idx_d        = '0;
          res_chosen_d = '0;
          res_expl_d   = 1'b0;
          res_value_d  = '0;
          case (qtl_pkg::op_e'(action_i))
            qtl_pkg::OP_SELECT: begin
              if (exploit) begin
                state_d = qtl_pkg::ST_SCAN;
              end else begin
                res_chosen_d = rand_wide[1:0];
                res_expl_d   = 1'b1;
                state_d      = qtl_pkg::ST_RESULT;
              end
            end
            qtl_pkg::OP_UPDATE: state_d = qtl_pkg::ST_SCAN;
            qtl_pkg::OP_LOAD:   state_d = qtl_pkg::ST_LOAD;
            qtl_pkg::OP_READ:   state_d = qtl_pkg::ST_RD;
            default:            state_d = qtl_pkg::ST_IDLE;
          endcase
        end
      end
      qtl_pkg::ST_SCAN: begin
        idx_d = idx_q + CW'(1);
        if (idx_q < CW'(NUM_ACTIONS)) begin
          mem_re = 1'b1;
        end
        if (idx_q == CW'(1)) begin
          best_d     = $signed(mem_rd);
          best_idx_d = '0;
        end else if (idx_q != '0 && take) begin
          best_d     = $signed(mem_rd);
          best_idx_d = AIW'(idx_q - CW'(1));
        end
        if (idx_q == CW'(NUM_ACTIONS)) begin
          if (op_q == qtl_pkg::OP_UPDATE) begin
            mem_re  = 1'b1;
            mem_ra  = cur_addr_q;
            state_d = qtl_pkg::ST_UPD_GO;
          end else begin
            res_chosen_d = 2'(best_idx_d);
            state_d      = qtl_pkg::ST_RESULT;
          end
        end
      end
      qtl_pkg::ST_UPD_GO: begin
        upd_req.valid = 1'b1;
        state_d       = qtl_pkg::ST_UPD_WAIT;
      end
      qtl_pkg::ST_UPD_WAIT: begin
        if (upd_rsp.valid) begin
          mem_we      = 1'b1;
          mem_wd      = upd_rsp.value;
          res_value_d = upd_rsp.value;
          state_d     = qtl_pkg::ST_RESULT;
        end
      end
      qtl_pkg::ST_RD: begin
        mem_re  = 1'b1;
        mem_ra  = cur_addr_q;
        state_d = qtl_pkg::ST_RD_DATA;
      end
      qtl_pkg::ST_RD_DATA: begin
        res_value_d = $signed(mem_rd);
        state_d     = qtl_pkg::ST_RESULT;
      end
      qtl_pkg::ST_LOAD: begin
        mem_we  = 1'b1;
        state_d = qtl_pkg::ST_RESULT;
      end
      qtl_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_chosen_d = res_chosen_q;
          out_expl_d   = res_expl_q;
          out_value_d  = res_value_q;
          state_d      = qtl_pkg::ST_IDLE;
        end
      end
      default: state_d = qtl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qtl_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      explore_q  <= qtl_pkg::EXPLORE_RST;
      learn_q    <= qtl_pkg::LEARN_RST;
      discount_q <= qtl_pkg::DISCOUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        qtl_pkg::CFG_EXPLORE:  explore_q  <= cfg_wdata_i;
        qtl_pkg::CFG_LEARN:    learn_q    <= cfg_wdata_i;
        qtl_pkg::CFG_DISCOUNT: discount_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    row_base_q   <= row_base_d;
    cur_addr_q   <= cur_addr_d;
    reward_q     <= reward_d;
    wval_q       <= wval_d;
    coins_q      <= coins_d;
    idx_q        <= idx_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    res_chosen_q <= res_chosen_d;
    res_expl_q   <= res_expl_d;
    res_value_q  <= res_value_d;
    out_chosen_q <= out_chosen_d;
    out_expl_q   <= out_expl_d;
    out_value_q  <= out_value_d;
  end

  qtl_mem #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (VW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_wa),
    .wdata_i(mem_wd),
    .re_i   (mem_re),
    .raddr_i(mem_ra),
    .rdata_o(mem_rd)
  );

  qtl_update u_update (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (upd_req),
    .rsp_o (upd_rsp)
  );

  assign out_valid_o     = out_valid_q;
  assign chosen_action_o = out_chosen_q;
  assign explored_o      = out_expl_q;
  assign read_value_o    = out_value_q;

`ifndef SYNTHESIS
  a_out_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == qtl_pkg::ST_RESULT))
    else $error("result left without passing the result state");

  a_upd_rsp_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_rsp.valid |-> state_q == qtl_pkg::ST_UPD_WAIT)
    else $error("update response arrived outside its wait state");

  a_explore_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && explored_o |-> read_value_o == '0)
    else $error("explored select carries a nonzero value");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == qtl_pkg::ST_SCAN |-> !mem_we)
    else $error("table written during a row scan");
`endif

endmodule
